// File: src/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
package qrs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COEF_W    = 16;
   localparam int ROOT_W    = 33;
   localparam int DISC_W    = 35;
   localparam int MAG_W     = 34;
   localparam int SQ_DIGITS = 17 + FRAC_BITS;
   localparam int SQ_RAD_W  = 2 * SQ_DIGITS;
   localparam int SQ_REM_W  = SQ_DIGITS + 2;
   localparam int DIV_W     = 18 + FRAC_BITS;
   localparam int DEN_W     = 17;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NAN       = 2'd1,
      ST_ZERO_LEAD = 2'd2
   } status_type;

   typedef struct packed {
      logic                     valid;
      status_type               status;
      logic                     cmplx;
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
   } sq_side_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic             cmplx;
      logic             neg0;
      logic             neg1;
      logic [DEN_W-1:0] den;
   } div_side_type;

endpackage

// File: src/qrs_sqrt_cell.sv
// One digit cell of the square root chain.
module qrs_sqrt_cell
   import qrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  sq_side_type          side_in,
   input  logic [SQ_RAD_W-1:0]  rad_in,
   input  logic [SQ_REM_W-1:0]  rem_in,
   input  logic [SQ_DIGITS-1:0] root_in,
   output sq_side_type          side_ff,
   output logic [SQ_RAD_W-1:0]  rad_ff,
   output logic [SQ_REM_W-1:0]  rem_ff,
   output logic [SQ_DIGITS-1:0] root_ff
);

   logic [SQ_REM_W+1:0]  rem_cat;
   logic [SQ_REM_W+1:0]  trial;
   logic [SQ_REM_W-1:0]  rem_in_nx;
   logic [SQ_DIGITS-1:0] root_in_nx;

   always_comb begin
      rem_cat = {rem_in, rad_in[SQ_RAD_W-1 -: 2]};
      trial   = {2'b00, root_in, 2'b01};
      if (rem_cat >= trial) begin
         rem_in_nx  = SQ_REM_W'(rem_cat - trial);
         root_in_nx = {root_in[SQ_DIGITS-2:0], 1'b1};
      end else begin
         rem_in_nx  = rem_cat[SQ_REM_W-1:0];
         root_in_nx = {root_in[SQ_DIGITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (advance) begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff  <= {rad_in[SQ_RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in_nx;
         root_ff <= root_in_nx;
      end
   end

endmodule

// File: src/qrs_div_cell.sv
// One quotient bit cell of the two-lane divider chain.
module qrs_div_cell
   import qrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  div_side_type     side_in,
   input  logic [DEN_W-1:0] rem_in  [2],
   input  logic [DIV_W-1:0] work_in [2],
   output div_side_type     side_ff,
   output logic [DEN_W-1:0] rem_ff  [2],
   output logic [DIV_W-1:0] work_ff [2]
);

   logic [DEN_W:0]   cat     [2];
   logic [DEN_W-1:0] rem_in_nx  [2];
   logic [DIV_W-1:0] work_in_nx [2];

   // shift the dividend out the top, quotient bits in at the bottom
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         cat[k] = {rem_in[k], work_in[k][DIV_W-1]};
         if (cat[k] >= {1'b0, side_in.den}) begin
            rem_in_nx[k]  = DEN_W'(cat[k] - {1'b0, side_in.den});
            work_in_nx[k] = {work_in[k][DIV_W-2:0], 1'b1};
         end else begin
            rem_in_nx[k]  = cat[k][DEN_W-1:0];
            work_in_nx[k] = {work_in[k][DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (advance) begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in_nx;
         work_ff <= work_in_nx;
      end
   end

endmodule

// File: src/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, cell chains, output register.
//
// Takes coefficients a, b, c and returns both roots of a*x^2+b*x+c as signed fixed
// point with FRAC_BITS fraction bits, rounded to nearest and saturated to 33 bits.
// The block is fully pipelined and accepts one transaction every cycle while no result
// waits on rsp_ready; the pipeline is a square root chain of one cell per root digit
// and a divider chain of one cell per quotient bit.
// The whole pipeline holds while a result waits on rsp_ready.
module quadratic_root_solver
   import qrs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [COEF_W-1:0] req_coef_a,
   input  logic signed [COEF_W-1:0] req_coef_b,
   input  logic signed [COEF_W-1:0] req_coef_c,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ROOT_W-1:0] rsp_first_root_real,
   output logic signed [ROOT_W-1:0] rsp_first_root_imag,
   output logic signed [ROOT_W-1:0] rsp_second_root_real,
   output logic signed [ROOT_W-1:0] rsp_second_root_imag,
   output logic [1:0]               rsp_status,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data
);

   localparam int SAT_W = (DIV_W > ROOT_W) ? DIV_W : ROOT_W + 1;

   function automatic logic [ROOT_W-1:0] sat_root(logic [DIV_W-1:0] q, logic neg);
      logic [SAT_W-1:0] qx;
      logic [SAT_W-1:0] lim;
      qx  = SAT_W'(q);
      lim = SAT_W'(1) << (ROOT_W - 1);
      if (neg) begin
         if (qx > lim) return {1'b1, {(ROOT_W-1){1'b0}}};
         return ROOT_W'(-qx);
      end
      if (qx >= lim) return {1'b0, {(ROOT_W-1){1'b1}}};
      return ROOT_W'(qx);
   endfunction

   logic advance;
   logic mode_ff;

   logic                     v0_ff, v1_ff;
   logic signed [COEF_W-1:0] a0_ff, b0_ff, c0_ff, a1_ff, b1_ff;
   logic signed [2*COEF_W-1:0] bb1_ff, ac1_ff;

   logic signed [DISC_W-1:0] disc;
   logic [MAG_W-1:0]         mag;
   sq_side_type              side2_in;
   sq_side_type              side2_ff;
   logic [SQ_RAD_W-1:0]      rad2_ff;

   sq_side_type          sq_side [SQ_DIGITS+1];
   logic [SQ_RAD_W-1:0]  sq_rad  [SQ_DIGITS+1];
   logic [SQ_REM_W-1:0]  sq_rem  [SQ_DIGITS+1];
   logic [SQ_DIGITS-1:0] sq_root [SQ_DIGITS+1];

   logic signed [DIV_W:0] base, rootx, n0_in, n1_in;
   logic signed [DIV_W:0] n0_ff, n1_ff;
   logic signed [COEF_W+1:0] a2x;
   logic [DEN_W-1:0]      den_in;
   logic                  aneg3_ff;
   div_side_type          side3_ff;

   logic [DIV_W:0]   m0, m1;
   div_side_type     side4_in;
   div_side_type     side4_ff;
   logic [DIV_W-1:0] work4_ff [2];
   logic [DEN_W-1:0] rem_zero [2];

   div_side_type     dv_side [DIV_W+1];
   logic [DEN_W-1:0] dv_rem  [DIV_W+1][2];
   logic [DIV_W-1:0] dv_work [DIV_W+1][2];

   div_side_type     last;
   logic [DIV_W-1:0] q0, q1;
   logic [ROOT_W-1:0] fr_in, fi_in, sr_in, si_in;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // front end: capture, multiply, discriminant
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         side2_ff <= '0;
      end else if (advance) begin
         v0_ff    <= req_valid;
         v1_ff    <= v0_ff;
         side2_ff <= side2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a0_ff   <= req_coef_a;
         b0_ff   <= req_coef_b;
         c0_ff   <= req_coef_c;
         bb1_ff  <= (2*COEF_W)'(b0_ff * b0_ff);
         ac1_ff  <= (2*COEF_W)'(a0_ff * c0_ff);
         a1_ff   <= a0_ff;
         b1_ff   <= b0_ff;
         rad2_ff <= {mag, {(2*FRAC_BITS){1'b0}}};
      end
   end

   always_comb begin
      disc = DISC_W'(bb1_ff) - (DISC_W'(ac1_ff) <<< 2);
      mag  = (disc < 0) ? MAG_W'(-disc) : MAG_W'(disc);
      side2_in.valid = v1_ff;
      side2_in.cmplx = disc < 0;
      side2_in.a     = a1_ff;
      side2_in.b     = b1_ff;
      if (a1_ff == '0) begin
         side2_in.status = ST_ZERO_LEAD;
      end else if (mode_ff && disc <= 0) begin
         side2_in.status = ST_NAN;
      end else begin
         side2_in.status = ST_OK;
      end
   end

   assign sq_side[0] = side2_ff;
   assign sq_rad[0]  = rad2_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar i = 0; i < SQ_DIGITS; i++) begin : g_sqrt
      qrs_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .side_in (sq_side[i]),
         .rad_in  (sq_rad[i]),
         .rem_in  (sq_rem[i]),
         .root_in (sq_root[i]),
         .side_ff (sq_side[i+1]),
         .rad_ff  (sq_rad[i+1]),
         .rem_ff  (sq_rem[i+1]),
         .root_ff (sq_root[i+1])
      );
   end

   // numerators and divisor
   always_comb begin
      base  = -((DIV_W+1)'(sq_side[SQ_DIGITS].b) <<< FRAC_BITS);
      rootx = (DIV_W+1)'(sq_root[SQ_DIGITS]);
      n0_in = sq_side[SQ_DIGITS].cmplx ? base  : base + rootx;
      n1_in = sq_side[SQ_DIGITS].cmplx ? rootx : base - rootx;
      a2x    = (COEF_W+2)'(sq_side[SQ_DIGITS].a) <<< 1;
      den_in = (a2x < 0) ? DEN_W'(-a2x) : DEN_W'(a2x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side3_ff <= '0;
      end else if (advance) begin
         side3_ff.valid  <= sq_side[SQ_DIGITS].valid;
         side3_ff.status <= sq_side[SQ_DIGITS].status;
         side3_ff.cmplx  <= sq_side[SQ_DIGITS].cmplx;
         side3_ff.neg0   <= 1'b0;
         side3_ff.neg1   <= 1'b0;
         side3_ff.den    <= den_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n0_ff    <= n0_in;
         n1_ff    <= n1_in;
         aneg3_ff <= sq_side[SQ_DIGITS].a < 0;
      end
   end

   // magnitudes plus half the divisor give round to nearest, ties away from zero
   always_comb begin
      m0 = (n0_ff < 0) ? (DIV_W+1)'(-n0_ff) : (DIV_W+1)'(n0_ff);
      m1 = (n1_ff < 0) ? (DIV_W+1)'(-n1_ff) : (DIV_W+1)'(n1_ff);
      side4_in      = side3_ff;
      side4_in.neg0 = (n0_ff < 0) ^ aneg3_ff;
      side4_in.neg1 = (n1_ff < 0) ^ aneg3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side4_ff <= '0;
      end else if (advance) begin
         side4_ff <= side4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work4_ff[0] <= DIV_W'(m0 + (DIV_W+1)'(side3_ff.den >> 1));
         work4_ff[1] <= DIV_W'(m1 + (DIV_W+1)'(side3_ff.den >> 1));
      end
   end

   assign rem_zero[0] = '0;
   assign rem_zero[1] = '0;
   assign dv_side[0]  = side4_ff;
   assign dv_rem[0]   = rem_zero;
   assign dv_work[0]  = work4_ff;

   for (genvar j = 0; j < DIV_W; j++) begin : g_div
      qrs_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .side_in (dv_side[j]),
         .rem_in  (dv_rem[j]),
         .work_in (dv_work[j]),
         .side_ff (dv_side[j+1]),
         .rem_ff  (dv_rem[j+1]),
         .work_ff (dv_work[j+1])
      );
   end

   // saturate and place the roots
   always_comb begin
      last  = dv_side[DIV_W];
      q0    = dv_work[DIV_W][0];
      q1    = dv_work[DIV_W][1];
      fr_in = '0;
      fi_in = '0;
      sr_in = '0;
      si_in = '0;
      if (last.status == ST_OK) begin
         fr_in = sat_root(q0, last.neg0);
         if (last.cmplx) begin
            sr_in = fr_in;
            fi_in = sat_root(q1, last.neg1);
            si_in = sat_root(q1, !last.neg1);
         end else begin
            sr_in = sat_root(q1, last.neg1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (advance) begin
         rsp_valid <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_first_root_real  <= fr_in;
         rsp_first_root_imag  <= fi_in;
         rsp_second_root_real <= sr_in;
         rsp_second_root_imag <= si_in;
         rsp_status           <= last.status;
      end
   end

   ast_zero_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ZERO_LEAD |->
         rsp_first_root_real == '0 && rsp_first_root_imag == '0 &&
         rsp_second_root_real == '0 && rsp_second_root_imag == '0)
      else $error("zero leading coefficient with nonzero roots");

   ast_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NAN |->
         rsp_first_root_real == '0 && rsp_first_root_imag == '0 &&
         rsp_second_root_real == '0 && rsp_second_root_imag == '0)
      else $error("rejected discriminant with nonzero roots");

   ast_conj: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK && rsp_first_root_imag != '0 |->
         rsp_first_root_real == rsp_second_root_real)
      else $error("complex roots are not a conjugate pair");

endmodule

// File: tb/sv/tb.sv
// Testbench for the quadratic root solver: random and directed coefficients, checked results.
`timescale 1ns / 100ps
module tb;
   import qrs_pkg::*;

   typedef struct {
      logic signed [COEF_W-1:0] a, b, c;
   } coef_set_type;

   typedef struct {
      logic signed [ROOT_W-1:0] r1, i1, r2, i2;
      status_type               st;
   } root_set_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [COEF_W-1:0] req_coef_a = 0, req_coef_b = 0, req_coef_c = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [ROOT_W-1:0] rsp_first_root_real, rsp_first_root_imag;
   logic signed [ROOT_W-1:0] rsp_second_root_real, rsp_second_root_imag;
   logic [1:0] rsp_status;
   logic csr_wr_en = 0;
   logic csr_wr_data = 0;

   quadratic_root_solver DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_coef_c(req_coef_c),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_first_root_real(rsp_first_root_real), .rsp_first_root_imag(rsp_first_root_imag),
      .rsp_second_root_real(rsp_second_root_real),
      .rsp_second_root_imag(rsp_second_root_imag),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   coef_set_type pending_coefs[$];
   root_set_type expected_roots[$];
   logic    real_only = 0;
   int      error_count = 0;
   int      send_idle_pct = 0, recv_idle_pct = 0;
   int      hold_off_cycles = 0;
   logic    send_pause = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint isqrt_fixed(longint mag);
      longint rem, root, trial, bits;
      rem = 0;
      root = 0;
      for (int i = SQ_DIGITS - 1; i >= 0; i--) begin
         bits = (i >= FRAC_BITS) ? ((mag >> (2 * (i - FRAC_BITS))) & 3) : 0;
         rem = (rem << 2) | bits;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint div_round_sat(longint num, longint den);
      longint n, d, q;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n + d / 2) / d;
      if ((num < 0) != (den < 0))
         return (q > 64'sd4294967296) ? -64'sd4294967296 : -q;
      return (q > 64'sd4294967295) ? 64'sd4294967295 : q;
   endfunction

   function automatic root_set_type solve_roots(coef_set_type cs);
      root_set_type rs;
      longint a, b, c, disc, base, root;
      a = longint'(cs.a);
      b = longint'(cs.b);
      c = longint'(cs.c);
      disc = b * b - 4 * a * c;
      rs = '{0, 0, 0, 0, ST_OK};
      if (a == 0) begin
         rs.st = ST_ZERO_LEAD;
      end else if (real_only && disc <= 0) begin
         rs.st = ST_NAN;
      end else begin
         base = -b * (64'sd1 << FRAC_BITS);
         if (disc >= 0) begin
            root = isqrt_fixed(disc);
            rs.r1 = ROOT_W'(div_round_sat(base + root, 2 * a));
            rs.r2 = ROOT_W'(div_round_sat(base - root, 2 * a));
         end else begin
            root = isqrt_fixed(-disc);
            rs.r1 = ROOT_W'(div_round_sat(base, 2 * a));
            rs.r2 = rs.r1;
            rs.i1 = ROOT_W'(div_round_sat(root, 2 * a));
            rs.i2 = ROOT_W'(div_round_sat(-root, 2 * a));
         end
      end
      return rs;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_roots.push_back(solve_roots('{req_coef_a, req_coef_b, req_coef_c}));
         end
         if (!req_valid || req_ready) begin
            if (pending_coefs.size() > 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid  <= 1;
               req_coef_a <= pending_coefs[0].a;
               req_coef_b <= pending_coefs[0].b;
               req_coef_c <= pending_coefs[0].c;
               void'(pending_coefs.pop_front());
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      root_set_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_roots.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            want = expected_roots.pop_front();
            if (rsp_first_root_real !== want.r1)
               report_mismatch("first_root_real", longint'(rsp_first_root_real),
                               longint'(want.r1));
            if (rsp_first_root_imag !== want.i1)
               report_mismatch("first_root_imag", longint'(rsp_first_root_imag),
                               longint'(want.i1));
            if (rsp_second_root_real !== want.r2)
               report_mismatch("second_root_real", longint'(rsp_second_root_real),
                               longint'(want.r2));
            if (rsp_second_root_imag !== want.i2)
               report_mismatch("second_root_imag", longint'(rsp_second_root_imag),
                               longint'(want.i2));
            if (rsp_status !== want.st)
               report_mismatch("status", longint'(rsp_status), longint'(want.st));
         end
      end
   end

   function automatic logic signed [COEF_W-1:0] rand_coef();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1, 2: return $signed(16'($urandom_range(40))) - 16'sd20;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_set(int a, int b, int c);
      coef_set_type cs;
      cs.a = COEF_W'(a);
      cs.b = COEF_W'(b);
      cs.c = COEF_W'(c);
      pending_coefs.push_back(cs);
   endtask

   task automatic queue_directed();
      queue_set(1, -3, 2);
      queue_set(1, 2, 1);
      queue_set(1, 0, 1);
      queue_set(0, 5, 7);
      queue_set(0, 0, 0);
      queue_set(32767, 32767, 32767);
      queue_set(-32768, -32768, -32768);
      queue_set(1, -32768, -32768);
      queue_set(1, 32767, -32768);
      queue_set(-1, -32768, 32767);
      queue_set(1, -32768, 0);
      queue_set(-32768, 1, 32767);
      queue_set(2, 4, 2);
      queue_set(-3, 1, 5);
      queue_set(1, 1, 0);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         queue_set(int'(rand_coef()), int'(rand_coef()), int'(rand_coef()));
   endtask

   task automatic drain();
      while (pending_coefs.size() > 0 || req_valid || expected_roots.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_mode(logic mode);
      @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= mode;
      real_only   <= mode;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      send_idle_pct = 22;
      recv_idle_pct = 79;
      queue_directed();
      queue_random(200);
      drain();
      write_mode(1);
      queue_directed();
      queue_random(200);
      @(posedge clock);
      hold_off_cycles <= 300;
      drain();
      // sender pause: every result is back before the next batch
      send_pause <= 1;
      repeat (20) @(posedge clock);
      send_pause <= 0;
      write_mode(0);
      send_idle_pct = 79;
      recv_idle_pct = 22;
      queue_random(250);
      drain();
      write_mode(1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(150);
      drain();
      write_mode(0);
      queue_random(220);
      drain();
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
